// File: rtl/cbd_pkg.sv
// Package for the chunked body decoder.
// Parse phases, result kinds, character codes and the hex digit decoder.
// No dependencies.
package cbd_pkg;

	localparam int LEN_BITS_DEF = 32;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_SIZE_LF,
		PH_DATA,
		PH_DATA_CR,
		PH_DATA_LF,
		PH_DONE,
		PH_FAIL
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_DONE    = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] data;
	} byte_beat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t r;
		r.ok = 1'b1;
		r.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.value = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: rtl/cbd_in_if.sv
// Input channel of the chunked body decoder: one raw body byte per beat.
// No dependencies.
interface cbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

// File: rtl/cbd_out_if.sv
// Result channel of the chunked body decoder: payload byte, completion or error.
// No dependencies.
interface cbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] kind;

	modport source (output valid, output out_byte, output kind, input ready);
	modport sink (input valid, input out_byte, input kind, output ready);
endinterface

// File: rtl/cbd_in_stage.sv
// Input register of the chunked body decoder.
// Depends on cbd_pkg and cbd_in_if.
module cbd_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	cbd_in_if.sink              body,
	input  logic                adv,
	output cbd_pkg::byte_beat_t beat_s1
);
	import cbd_pkg::*;

	logic       vld_s1;
	logic [7:0] data_s1;

	assign body.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (body.ready) begin
			vld_s1 <= body.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (body.valid && body.ready) begin
			data_s1 <= body.data_byte;
		end
	end

	assign beat_s1.vld  = vld_s1;
	assign beat_s1.data = data_s1;
endmodule

// File: rtl/cbd_parser.sv
// Chunk framing state machine and result register.
// Depends on cbd_pkg and cbd_out_if.
module cbd_parser #(
	parameter int LEN_BITS = cbd_pkg::LEN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cbd_pkg::byte_beat_t beat_s1,
	output logic                adv,
	cbd_out_if.source           result
);
	import cbd_pkg::*;

	phase_t              state_q, state_d;
	logic [LEN_BITS-1:0] acc_q, acc_d;
	logic [LEN_BITS-1:0] rem_q, rem_d;
	logic                fin_q, fin_d;
	logic                emit;
	kind_t               kind_d;
	logic [7:0]          byte_d;
	hex_digit_t          hd;
	logic                take;

	logic                out_vld_q;
	logic [7:0]          out_byte_q;
	kind_t               out_kind_q;

	assign adv  = !out_vld_q || result.ready;
	assign take = beat_s1.vld && adv;
	assign hd   = hex_decode(beat_s1.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_SIZE;
			acc_q   <= '0;
			rem_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			acc_q   <= acc_d;
			rem_q   <= rem_d;
			fin_q   <= fin_d;
		end
	end

	always_comb begin
		state_d = state_q;
		acc_d   = acc_q;
		rem_d   = rem_q;
		fin_d   = fin_q;
		emit    = 1'b0;
		kind_d  = KIND_PAYLOAD;
		byte_d  = 8'd0;
		if (take) begin
			unique case (state_q)
				PH_SIZE: begin
					if (beat_s1.data == CH_CR) begin
						state_d = PH_SIZE_LF;
					end else if (!hd.ok || acc_q[LEN_BITS-1 -: 4] != 4'd0) begin
						state_d = PH_FAIL;
						emit    = 1'b1;
						kind_d  = KIND_ERROR;
					end else begin
						acc_d = {acc_q[LEN_BITS-5:0], hd.value};
					end
				end
				PH_SIZE_LF: begin
					if (beat_s1.data != CH_LF) begin
						state_d = PH_FAIL;
						emit    = 1'b1;
						kind_d  = KIND_ERROR;
					end else begin
						if (acc_q == '0) begin
							fin_d   = 1'b1;
							state_d = PH_DATA_CR;
						end else begin
							rem_d   = acc_q;
							state_d = PH_DATA;
						end
						acc_d = '0;
					end
				end
				PH_DATA: begin
					rem_d  = rem_q - LEN_BITS'(1);
					emit   = 1'b1;
					kind_d = KIND_PAYLOAD;
					byte_d = beat_s1.data;
					if (rem_q == LEN_BITS'(1)) begin
						state_d = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					if (beat_s1.data != CH_CR) begin
						state_d = PH_FAIL;
						emit    = 1'b1;
						kind_d  = KIND_ERROR;
					end else begin
						state_d = PH_DATA_LF;
					end
				end
				PH_DATA_LF: begin
					if (beat_s1.data != CH_LF) begin
						state_d = PH_FAIL;
						emit    = 1'b1;
						kind_d  = KIND_ERROR;
					end else if (fin_q) begin
						state_d = PH_DONE;
						emit    = 1'b1;
						kind_d  = KIND_DONE;
					end else begin
						state_d = PH_SIZE;
						acc_d   = '0;
					end
				end
				PH_DONE, PH_FAIL: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_byte_q <= byte_d;
			out_kind_q <= kind_d;
		end
	end

	assign result.valid    = out_vld_q;
	assign result.out_byte = out_byte_q;
	assign result.kind     = out_kind_q;
endmodule

// File: rtl/chunked_body_decoder_core.sv
// Chunked body decoder, top level.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if, cbd_in_stage and cbd_parser.
//
// Decodes an HTTP chunked-encoded body, one byte per beat, and returns each
// payload byte (kind 0), one completion (kind 1) after the zero-size chunk's
// CR LF, or one format error (kind 2); after either, all bytes are dropped
// until reset. Throughput is one byte per cycle while the result register is not
// stalled: the input register feeds the framing state machine, whose update writes the
// result register. A byte's result passes through the input register and then the result
// register; the input stays ready while the result register is empty or being taken.
// Sizes are limited to LEN_BITS bits.
module chunked_body_decoder_core #(
	parameter int LEN_BITS = cbd_pkg::LEN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cbd_in_if.sink    body,
	cbd_out_if.source result
);
	import cbd_pkg::*;

	byte_beat_t beat_s1;
	logic       adv;

	cbd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.body    (body),
		.adv     (adv),
		.beat_s1 (beat_s1)
	);

	cbd_parser #(
		.LEN_BITS (LEN_BITS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat_s1 (beat_s1),
		.adv     (adv),
		.result  (result)
	);
endmodule

// File: verif/cbd_checker.sv
// Checker for the chunked body decoder: watches both channels, decodes each accepted
// input beat with its own framing model and compares every result beat in order.
// Depends on cbd_pkg, cbd_in_if and cbd_out_if.
module cbd_checker #(
	parameter int LEN_BITS = cbd_pkg::LEN_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	cbd_in_if    body,
	cbd_out_if   result,
	output int   fail_count,
	output int   pending,
	output int   results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import cbd_pkg::*;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
	} result_beat_t;

	phase_t                ph;
	logic [LEN_BITS-1:0]   size_acc;
	logic [LEN_BITS-1:0]   remaining;
	logic                  final_chunk;
	result_beat_t          expected_results[$];
	result_beat_t          want;
	result_beat_t          predicted;
	bit                    emits;
	int                    mismatches;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	task automatic decode_byte(input logic [7:0] c, output bit has, output result_beat_t r);
		int d;
		bit bad;
		has = 1'b0;
		bad = 1'b0;
		r = '{out_byte: 8'h00, kind: KIND_PAYLOAD};
		case (ph)
			PH_SIZE: begin
				if (c == CH_CR) begin
					ph = PH_SIZE_LF;
				end else begin
					d = hex_nibble(c);
					if (d < 0 || size_acc[LEN_BITS-1 -: 4] != 4'd0) begin
						bad = 1'b1;
					end else begin
						size_acc = {size_acc[LEN_BITS-5:0], 4'(d)};
					end
				end
			end
			PH_SIZE_LF: begin
				if (c != CH_LF) begin
					bad = 1'b1;
				end else begin
					if (size_acc == '0) begin
						final_chunk = 1'b1;
						ph = PH_DATA_CR;
					end else begin
						remaining = size_acc;
						ph = PH_DATA;
					end
					size_acc = '0;
				end
			end
			PH_DATA: begin
				remaining = remaining - LEN_BITS'(1);
				if (remaining == '0) ph = PH_DATA_CR;
				has = 1'b1;
				r.out_byte = c;
			end
			PH_DATA_CR: begin
				if (c != CH_CR) bad = 1'b1;
				else ph = PH_DATA_LF;
			end
			PH_DATA_LF: begin
				if (c != CH_LF) begin
					bad = 1'b1;
				end else if (final_chunk) begin
					ph = PH_DONE;
					has = 1'b1;
					r.kind = KIND_DONE;
				end else begin
					ph = PH_SIZE;
					size_acc = '0;
				end
			end
			default: ;
		endcase
		if (bad) begin
			ph = PH_FAIL;
			has = 1'b1;
			r = '{out_byte: 8'h00, kind: KIND_ERROR};
		end
	endtask

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_SIZE;
			size_acc = '0;
			remaining = '0;
			final_chunk = 1'b0;
			expected_results.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (result.valid && result.ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result: byte %02h kind %0d",
						result.out_byte, result.kind));
				end else begin
					want = expected_results.pop_front();
					if (result.out_byte !== want.out_byte || result.kind !== want.kind) begin
						note_mismatch($sformatf(
							"result %0d: expected byte %02h kind %0d, got byte %02h kind %0d",
							results_seen, want.out_byte, want.kind,
							result.out_byte, result.kind));
					end
				end
			end
			if (body.valid && body.ready) begin
				decode_byte(body.data_byte, emits, predicted);
				if (emits) expected_results.push_back(predicted);
			end
			pending <= expected_results.size();
			fail_count <= mismatches;
		end
	end

endmodule

// File: verif/tb.sv
// Testbench top for chunked_body_decoder_core: drives one long chunked body with bursty
// input and a stalling receiver, then closes it with a random ending; cbd_checker scores it.
// Depends on cbd_pkg, cbd_in_if, cbd_out_if, cbd_checker and the decoder RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cbd_pkg::*;

	localparam int LEN_BITS = LEN_BITS_DEF;

	logic  clk;
	logic  arst_n;
	int    fail_count;
	int    pending;
	int    results_seen;
	int    sent_count;
	int    burst_left;
	int    body_chunks;
	string ending;

	cbd_in_if  body_ch();
	cbd_out_if result_ch();

	chunked_body_decoder_core #(.LEN_BITS(LEN_BITS)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_ch),
		.result (result_ch)
	);

	cbd_checker #(.LEN_BITS(LEN_BITS)) u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.body         (body_ch),
		.result       (result_ch),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_400_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
		if (v < 4'd10) return 8'h30 + 8'(v);
		return (upper ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
	endfunction

	function automatic logic [7:0] other_than(input logic [7:0] x);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == x);
		return b;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat is taken
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0) begin
				gap = 0;
				burst_left = $urandom_range(100, 200);
			end else begin
				gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
				burst_left = $urandom_range(1, 40);
			end
			if (gap > 0) begin
				body_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		body_ch.valid <= 1'b1;
		body_ch.data_byte <= b;
		do @(posedge clk); while (!body_ch.ready);
		sent_count++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic push_crlf();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	task automatic push_size(input logic [LEN_BITS-1:0] v, input int zeros);
		int n;
		n = 1;
		while (n < LEN_BITS / 4 && (v >> (4 * n)) != '0) n++;
		repeat (zeros) push_byte("0");
		for (int i = n - 1; i >= 0; i--)
			push_byte(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))));
		push_crlf();
	endtask

	task automatic push_chunk(input int len);
		logic [7:0] b;
		push_size(LEN_BITS'(len), ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
		repeat (len) begin
			case ($urandom_range(0, 19))
				0: b = CH_CR;
				1: b = CH_LF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			push_byte(b);
		end
		push_crlf();
	endtask

	initial begin : sink_side
		int  mode;
		int  mode_left;
		int  hold_left;
		bit  hold_done;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			// long hold-off mid-body so the input backs up
			if (!hold_done && sent_count >= 300) begin
				hold_left = 160;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= 1'($urandom_range(0, 1));
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= (mode_left % 3 != 0);
				endcase
			end
		end
	end

	initial begin : source_side
		int         waited;
		int         len;
		logic [7:0] b;
		arst_n = 1'b0;
		body_ch.valid = 1'b0;
		body_ch.data_byte = 8'h00;
		sent_count = 0;
		burst_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: extreme payload values, CR inside payload, long run of leading zeros
		push_size(1, 0);
		push_byte(8'h00);
		push_crlf();
		push_size(2, 8);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_crlf();
		body_chunks = 2;

		while (sent_count < 880) begin
			case ($urandom_range(0, 99)) inside
				[0:84]:  len = $urandom_range(1, 16);
				[85:96]: len = $urandom_range(17, 64);
				default: len = $urandom_range(65, 200);
			endcase
			push_chunk(len);
			body_chunks++;
		end

		case ($urandom_range(0, 7))
			0: begin
				ending = "zero-size chunk";
				push_size(0, $urandom_range(0, 3));
				push_crlf();
			end
			1: begin
				ending = "empty size line";
				push_crlf();
				push_crlf();
			end
			2: begin
				ending = "non-hex size digit";
				if ($urandom_range(0, 1)) push_byte(hex_char(4'($urandom_range(0, 15)), 1'b1));
				do b = 8'($urandom_range(0, 255));
				while (b == CH_CR || (b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
					(b >= "A" && b <= "F"));
				push_byte(b);
			end
			3: begin
				ending = "size overflow";
				push_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
				repeat (LEN_BITS / 4)
					push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
			end
			4: begin
				ending = "missing LF after size line";
				push_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
				push_byte(CH_CR);
				push_byte(other_than(CH_LF));
			end
			5: begin
				ending = "missing CR after chunk data";
				push_size(3, 0);
				repeat (3) push_byte(8'($urandom_range(0, 255)));
				push_byte(other_than(CH_CR));
			end
			6: begin
				ending = "missing LF after chunk data";
				push_size(3, 0);
				repeat (3) push_byte(8'($urandom_range(0, 255)));
				push_byte(CH_CR);
				push_byte(other_than(CH_LF));
			end
			default: begin
				ending = "broken close of final chunk";
				push_size(0, 0);
				if ($urandom_range(0, 1)) begin
					push_byte(other_than(CH_CR));
				end else begin
					push_byte(CH_CR);
					push_byte(other_than(CH_LF));
				end
			end
		endcase

		// everything after the ending must be dropped
		push_chunk(4);
		repeat ($urandom_range(16, 40)) push_byte(8'($urandom_range(0, 255)));
		body_ch.valid <= 1'b0;

		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (20) @(negedge clk);

		$display("sent %0d body bytes, %0d chunks before the ending, %0d results checked",
			sent_count, body_chunks, results_seen);
		$display("body ended by %s; output held off 160 cycles mid-body", ending);
		if (pending != 0) $display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
